// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    `ASSERT_CLK(label, clk, rstn, !(expr), msg)

`endif

// ===== hdl/swd_seq_pkg.sv =====
package swd_seq_pkg;

    localparam int unsigned CNT_W  = 6;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned TBIT_W = 33;

    localparam logic [2:0] REQ_WRITE     = 3'd0;
    localparam logic [2:0] REQ_WRITE_PAR = 3'd1;
    localparam logic [2:0] REQ_READ      = 3'd2;
    localparam logic [2:0] REQ_READ_PAR  = 3'd3;
    localparam logic [2:0] REQ_LINE_RST  = 3'd4;

    localparam logic [CNT_W-1:0] MAX_BITS = 6'd32;

    typedef enum logic [2:0] {
        PK_TURN,
        PK_WBIT,
        PK_WPAR,
        PK_RBIT,
        PK_RPAR,
        PK_LRST
    } pulse_kind_t;

    // Controller to datapath.
    typedef struct packed {
        logic        load;
        logic        emit;
        pulse_kind_t kind;
        logic        last;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic valid_req;
        logic is_read;
        logic has_parity;
        logic is_reset;
        logic cnt_zero;
        logic data_last;
        logic rst_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/swd_seq_datapath.sv =====
`include "assert_macros.svh"

module swd_seq_datapath #(
    parameter int unsigned RESET_PULSES = 50
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  swd_seq_pkg::ctrl_cmd_t   cmd,
    output swd_seq_pkg::dp_status_t  sts,
    input  logic [2:0]               s_req_type,
    input  logic [31:0]              s_write_data,
    input  logic [5:0]               s_bit_count,
    input  logic [32:0]              s_target_bits,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_swdio_drive,
    output logic                     m_swdio_level,
    output logic [31:0]              m_read_data,
    output logic                     m_parity_error,
    output logic                     m_last_pulse
);
    import swd_seq_pkg::*;

    logic [2:0]        req_reg;
    logic [DATA_W-1:0] wdata_reg;
    logic [TBIT_W-1:0] tbits_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              par_reg, par_next;

    logic              m_valid_reg;
    logic              drive_reg, drive_next;
    logic              level_reg, level_next;
    logic [DATA_W-1:0] rdata_reg, rdata_next;
    logic              perr_reg, perr_next;
    logic              last_reg;

    logic              bit_w, bit_r, par_sample;
    logic [CNT_W-1:0]  cnt_sat;

    assign cnt_sat    = (s_bit_count > MAX_BITS) ? MAX_BITS : s_bit_count;
    assign bit_w      = wdata_reg[idx_reg[4:0]];
    assign bit_r      = tbits_reg[idx_reg];
    assign par_sample = tbits_reg[cnt_reg];

    always_comb begin
        sts.valid_req  = (req_reg <= REQ_LINE_RST);
        sts.is_read    = (req_reg == REQ_READ) || (req_reg == REQ_READ_PAR);
        sts.has_parity = (req_reg == REQ_WRITE_PAR) || (req_reg == REQ_READ_PAR);
        sts.is_reset   = (req_reg == REQ_LINE_RST);
        sts.cnt_zero   = (cnt_reg == '0);
        sts.data_last  = ((idx_reg + 6'd1) == cnt_reg);
        sts.rst_last   = (idx_reg == CNT_W'(RESET_PULSES - 1));
        sts.out_free   = !m_valid_reg || m_ready;
    end

    // Build the next pulse word and advance the bit walk.
    always_comb begin
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        par_next   = par_reg;
        drive_next = 1'b0;
        level_next = 1'b0;
        rdata_next = '0;
        perr_next  = 1'b0;
        unique case (cmd.kind)
            PK_TURN: begin
                rdata_next = cmd.last ? acc_reg : '0;
            end
            PK_WBIT: begin
                drive_next = 1'b1;
                level_next = bit_w;
                par_next   = par_reg ^ bit_w;
                idx_next   = idx_reg + 6'd1;
            end
            PK_WPAR: begin
                drive_next = 1'b1;
                level_next = par_reg;
            end
            PK_RBIT: begin
                if (bit_r) begin
                    acc_next = acc_reg | (DATA_W'(1) << idx_reg[4:0]);
                end
                par_next   = par_reg ^ bit_r;
                idx_next   = idx_reg + 6'd1;
                rdata_next = cmd.last ? acc_next : '0;
            end
            PK_RPAR: begin
                rdata_next = acc_reg;
                perr_next  = par_reg ^ par_sample;
            end
            PK_LRST: begin
                drive_next = 1'b1;
                level_next = 1'b1;
                idx_next   = idx_reg + 6'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_req_type;
            wdata_reg <= s_write_data;
            tbits_reg <= s_target_bits;
            cnt_reg   <= cnt_sat;
            idx_reg   <= '0;
            acc_reg   <= '0;
            par_reg   <= 1'b0;
        end else if (cmd.emit) begin
            idx_reg <= idx_next;
            acc_reg <= acc_next;
            par_reg <= par_next;
        end
        if (cmd.emit) begin
            drive_reg <= drive_next;
            level_reg <= level_next;
            rdata_reg <= rdata_next;
            perr_reg  <= perr_next;
            last_reg  <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_swdio_drive  = drive_reg;
    assign m_swdio_level  = level_reg;
    assign m_read_data    = rdata_reg;
    assign m_parity_error = perr_reg;
    assign m_last_pulse   = last_reg;

    `ASSERT_CLK(a_bit_in_range, aclk, aresetn, cmd.emit && (cmd.kind == PK_RBIT || cmd.kind == PK_WBIT) |-> idx_reg < cnt_reg, "data bit index past bit count")
    `ASSERT_NEVER(a_perr_not_last, aclk, aresetn, m_valid && m_parity_error && !m_last_pulse, "parity error off the last pulse")

endmodule

// ===== hdl/swd_seq_ctrl.sv =====
`include "assert_macros.svh"

module swd_seq_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  swd_seq_pkg::dp_status_t  sts,
    output swd_seq_pkg::ctrl_cmd_t   cmd
);
    import swd_seq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TURN,
        ST_DATA,
        ST_PAR,
        ST_RST
    } state_t;

    state_t state_reg, state_next, body_state;
    logic   line_is_input_reg, line_is_input_next;

    // First body state, chosen by the command; entered after a turnaround or straight from the start state.
    always_comb begin
        priority if (sts.is_reset) begin
            body_state = ST_RST;
        end else if (!sts.cnt_zero) begin
            body_state = ST_DATA;
        end else if (sts.has_parity) begin
            body_state = ST_PAR;
        end else begin
            body_state = ST_IDLE;
        end
    end

    always_comb begin
        state_next         = state_reg;
        line_is_input_next = line_is_input_reg;
        cmd.load           = 1'b0;
        cmd.emit           = 1'b0;
        cmd.kind           = PK_TURN;
        cmd.last           = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                priority if (!sts.valid_req) begin
                    state_next = ST_IDLE;
                end else if (sts.is_read != line_is_input_reg) begin
                    line_is_input_next = sts.is_read;
                    state_next         = ST_TURN;
                end else begin
                    state_next = body_state;
                end
            end
            ST_TURN: begin
                cmd.kind = PK_TURN;
                cmd.last = (body_state == ST_IDLE);
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = body_state;
                end
            end
            ST_DATA: begin
                cmd.kind = sts.is_read ? PK_RBIT : PK_WBIT;
                cmd.last = sts.data_last && !sts.has_parity;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.data_last) begin
                        state_next = sts.has_parity ? ST_PAR : ST_IDLE;
                    end
                end
            end
            ST_PAR: begin
                cmd.kind = sts.is_read ? PK_RPAR : PK_WPAR;
                cmd.last = 1'b1;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RST: begin
                cmd.kind = PK_LRST;
                cmd.last = sts.rst_last;
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.rst_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            line_is_input_reg <= 1'b0;
        end else begin
            state_reg         <= state_next;
            line_is_input_reg <= line_is_input_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    `ASSERT_CLK(a_emit_free, aclk, aresetn, cmd.emit |-> sts.out_free, "pulse issued into a full output register")
    `ASSERT_CLK(a_dir_turn, aclk, aresetn, line_is_input_reg != $past(line_is_input_reg) |-> state_reg == ST_TURN, "direction changed without turnaround")

endmodule

// ===== hdl/swd_bit_sequencer_core.sv =====
// Flow: a taken command word is latched in the datapath, the controller checks it in its start state,
//   and the first pulse word is then registered into the output register once that register is free.
// Throughput: one pulse word per cycle while m_ready stays high.
// The next command is taken once the last pulse word of this one sits in the output register.
// Reset (aresetn low, synchronous): the controller returns to idle, the line direction
//   returns to master-driving and the output register is emptied.
module swd_bit_sequencer_core #(
    parameter int unsigned RESET_PULSES = 50
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_write_data,
    input  logic [5:0]  s_bit_count,
    input  logic [32:0] s_target_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_swdio_drive,
    output logic        m_swdio_level,
    output logic [31:0] m_read_data,
    output logic        m_parity_error,
    output logic        m_last_pulse
);
    import swd_seq_pkg::*;

    // Command flow: the controller steps through turnaround, data bits, parity
    // and line reset pulses; the datapath latches the command word, walks the
    // bit index, folds parity and gathers read bits, and owns the output register.
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    swd_seq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    swd_seq_datapath #(
        .RESET_PULSES (RESET_PULSES)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_req_type     (s_req_type),
        .s_write_data   (s_write_data),
        .s_bit_count    (s_bit_count),
        .s_target_bits  (s_target_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_swdio_drive  (m_swdio_drive),
        .m_swdio_level  (m_swdio_level),
        .m_read_data    (m_read_data),
        .m_parity_error (m_parity_error),
        .m_last_pulse   (m_last_pulse)
    );

endmodule

// ===== dv/swd_bit_sequencer_core_tb.sv =====
module swd_bit_sequencer_core_tb;

    import swd_seq_pkg::*;

    localparam int unsigned LINE_RST_PULSES = 50;
    localparam int          DOG_LIMIT       = 3000;
    localparam int          LONG_HOLD       = 400;
    localparam int          MAX_REPORTS     = 10;

    // First code past the defined commands; the block must ignore these.
    localparam logic [2:0] REQ_UNDEF_LO = REQ_LINE_RST + 3'd1;

    typedef struct packed {
        logic [2:0]  req;
        logic [31:0] wdata;
        logic [5:0]  cnt;
        logic [32:0] tbits;
    } swd_cmd_t;

    typedef struct packed {
        logic        drive;
        logic        level;
        logic [31:0] rdata;
        logic        perr;
        logic        last;
    } swd_pulse_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type     = '0;
    logic [31:0] s_write_data   = '0;
    logic [5:0]  s_bit_count    = '0;
    logic [32:0] s_target_bits  = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic        m_swdio_drive;
    logic        m_swdio_level;
    logic [31:0] m_read_data;
    logic        m_parity_error;
    logic        m_last_pulse;

    swd_cmd_t   cmd_pending[$];
    swd_pulse_t pulse_expq[$];
    swd_cmd_t   next_cmd;

    // Line direction as the checker sees it: 1 once the target owns the line.
    logic       tgt_owns_line = 1'b0;
    logic       in_taken      = 1'b0;
    int         err_count     = 0;
    int         tx_idle_pct   = 0;
    int         rx_idle_pct   = 0;
    int         hold_left     = 0;
    int         dog_cycles    = 0;
    logic       long_hold_req  = 1'b0;
    logic       long_hold_done = 1'b0;

    swd_bit_sequencer_core #(
        .RESET_PULSES (LINE_RST_PULSES)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_write_data   (s_write_data),
        .s_bit_count    (s_bit_count),
        .s_target_bits  (s_target_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_swdio_drive  (m_swdio_drive),
        .m_swdio_level  (m_swdio_level),
        .m_read_data    (m_read_data),
        .m_parity_error (m_parity_error),
        .m_last_pulse   (m_last_pulse)
    );

    always #5 aclk = ~aclk;

    // Expand one command word into the pulse words it must produce.
    function automatic void predict_pulses(input swd_cmd_t cmd);
        swd_pulse_t pq[$];
        swd_pulse_t p;
        logic [5:0] n;
        logic       want_in;
        logic       par;
        logic [31:0] acc;
        if (cmd.req >= REQ_UNDEF_LO) return;
        n = (cmd.cnt > MAX_BITS) ? MAX_BITS : cmd.cnt;
        want_in = (cmd.req == REQ_READ) || (cmd.req == REQ_READ_PAR);
        // Insert a released turnaround pulse on a direction change.
        if (want_in != tgt_owns_line) begin
            tgt_owns_line = want_in;
            pq.push_back('0);
        end
        par = 1'b0;
        acc = '0;
        case (cmd.req)
            REQ_LINE_RST: begin
                for (int i = 0; i < LINE_RST_PULSES; i++)
                    pq.push_back('{drive: 1'b1, level: 1'b1, rdata: '0, perr: 1'b0, last: 1'b0});
            end
            REQ_WRITE, REQ_WRITE_PAR: begin
                for (int i = 0; i < n; i++) begin
                    par ^= cmd.wdata[i];
                    pq.push_back('{drive: 1'b1, level: cmd.wdata[i], rdata: '0,
                                   perr: 1'b0, last: 1'b0});
                end
                if (cmd.req == REQ_WRITE_PAR)
                    pq.push_back('{drive: 1'b1, level: par, rdata: '0, perr: 1'b0, last: 1'b0});
            end
            default: begin
                for (int i = 0; i < n; i++) begin
                    acc[i] = cmd.tbits[i];
                    par ^= cmd.tbits[i];
                    pq.push_back('0);
                end
                if (cmd.req == REQ_READ_PAR) begin
                    par ^= cmd.tbits[n];
                    pq.push_back('0);
                end
                // Gathered data and parity ride on the final pulse.
                if (pq.size() != 0) begin
                    p = pq.pop_back();
                    p.rdata = acc;
                    p.perr = (cmd.req == REQ_READ_PAR) ? par : 1'b0;
                    pq.push_back(p);
                end
            end
        endcase
        if (pq.size() != 0) begin
            p = pq.pop_back();
            p.last = 1'b1;
            pq.push_back(p);
        end
        foreach (pq[i]) pulse_expq.push_back(pq[i]);
    endfunction

    task automatic report_bad(input string why, input swd_pulse_t want, input swd_pulse_t got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display({"ERROR %s: exp drv=%0b lvl=%0b rd=%08h perr=%0b last=%0b",
                      " | got drv=%0b lvl=%0b rd=%08h perr=%0b last=%0b"},
                     why, want.drive, want.level, want.rdata, want.perr, want.last,
                     got.drive, got.level, got.rdata, got.perr, got.last);
    endtask

    task automatic queue_cmd(input logic [2:0] req, input logic [31:0] wdata,
                             input logic [5:0] cnt, input logic [32:0] tbits);
        cmd_pending.push_back('{req: req, wdata: wdata, cnt: cnt, tbits: tbits});
    endtask

    function automatic swd_cmd_t rand_cmd();
        swd_cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            c.req = REQ_UNDEF_LO + 3'($urandom_range(0, 2));
        else if (r < 14)
            c.req = REQ_LINE_RST;
        else
            c.req = 3'($urandom_range(REQ_WRITE, REQ_READ_PAR));
        r = $urandom_range(0, 99);
        if (r < 8)
            c.cnt = '0;
        else if (r < 14)
            c.cnt = 6'($urandom_range(MAX_BITS + 1, 63));
        else if (r < 20)
            c.cnt = MAX_BITS;
        else
            c.cnt = 6'($urandom_range(1, MAX_BITS));
        c.wdata = $urandom();
        c.tbits = {1'($urandom_range(0, 1)), 32'($urandom())};
        return c;
    endfunction

    // Push random commands until n of them are ones the block acts on.
    task automatic queue_random(input int n);
        swd_cmd_t c;
        int done;
        done = 0;
        while (done < n) begin
            c = rand_cmd();
            cmd_pending.push_back(c);
            if (c.req < REQ_UNDEF_LO) done++;
        end
    endtask

    // Hold the sender until every queued word is taken and every pulse is back.
    task automatic drain();
        while (cmd_pending.size() != 0 || s_valid || pulse_expq.size() != 0)
            @(posedge aclk);
    endtask

    // Driver: advance to the next command word once the current one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (cmd_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                next_cmd = cmd_pending.pop_front();
                s_valid       <= 1'b1;
                s_req_type    <= next_cmd.req;
                s_write_data  <= next_cmd.wdata;
                s_bit_count   <= next_cmd.cnt;
                s_target_bits <= next_cmd.tbits;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when asked.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (long_hold_req && !long_hold_done) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Monitor: predict on each taken command word, check each pulse word.
    always @(posedge aclk) begin
        swd_pulse_t got;
        swd_pulse_t want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready)
                predict_pulses('{req: s_req_type, wdata: s_write_data,
                                 cnt: s_bit_count, tbits: s_target_bits});
            if (m_valid && m_ready) begin
                got = '{drive: m_swdio_drive, level: m_swdio_level, rdata: m_read_data,
                        perr: m_parity_error, last: m_last_pulse};
                if (pulse_expq.size() == 0) begin
                    report_bad("unexpected pulse", '0, got);
                end else begin
                    want = pulse_expq.pop_front();
                    if (got !== want) report_bad("pulse mismatch", want, got);
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            dog_cycles = 0;
        end else begin
            dog_cycles++;
            if (dog_cycles >= DOG_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", DOG_LIMIT);
                $display("swd_bit_sequencer_core_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 36;
        rx_idle_pct = 88;

        // Directed: field extremes, every command, direction changes.
        queue_cmd(REQ_WRITE,     32'hFFFF_FFFF, MAX_BITS, '0);
        queue_cmd(REQ_WRITE_PAR, 32'hAAAA_AAAA, MAX_BITS, '0);
        queue_cmd(REQ_WRITE_PAR, 32'h0000_0015, 6'd7,     '0);
        queue_cmd(REQ_WRITE,     32'h0000_0001, 6'd1,     '0);
        // Zero bits while already driving: nothing comes out.
        queue_cmd(REQ_WRITE,     32'hFFFF_FFFF, 6'd0,     '0);
        // Zero bits with parity: only the parity bit.
        queue_cmd(REQ_WRITE_PAR, 32'hFFFF_FFFF, 6'd0,     '0);
        queue_cmd(REQ_WRITE,     32'h0000_0000, MAX_BITS, '0);
        queue_cmd(REQ_READ,      '0, MAX_BITS, 33'h1_FFFF_FFFF);
        queue_cmd(REQ_READ,      '0, 6'd0,     33'h1_FFFF_FFFF);
        queue_cmd(REQ_READ_PAR,  '0, MAX_BITS, 33'h1_0000_0001);
        // Parity failure, then parity-only sample with a failure.
        queue_cmd(REQ_READ_PAR,  '0, 6'd4,     33'h0_0000_0001);
        queue_cmd(REQ_READ_PAR,  '0, 6'd0,     33'h0_0000_0001);
        queue_cmd(REQ_READ,      '0, 6'd16,    33'h0_0000_0000);
        // Undefined codes while the target owns the line: no turnaround after.
        queue_cmd(REQ_UNDEF_LO,        32'hFFFF_FFFF, MAX_BITS, 33'h1_FFFF_FFFF);
        queue_cmd(REQ_UNDEF_LO + 3'd1, 32'hFFFF_FFFF, 6'd63,    33'h1_FFFF_FFFF);
        queue_cmd(REQ_UNDEF_LO + 3'd2, 32'h0,         6'd0,     33'h0);
        queue_cmd(REQ_READ,      '0, 6'd1,     33'h0_0000_0001);
        // Zero-bit reads and writes that only turn the line around; line resets ignore the bit count.
        queue_cmd(REQ_WRITE,     32'h0, 6'd0, '0);
        queue_cmd(REQ_READ,      '0,    6'd0, '0);
        queue_cmd(REQ_LINE_RST,  32'h0, 6'd0, '0);
        queue_cmd(REQ_LINE_RST,  32'hFFFF_FFFF, 6'd63, 33'h1_FFFF_FFFF);
        // Counts above the maximum saturate.
        queue_cmd(REQ_WRITE_PAR, 32'h1234_5678, 6'd63, '0);
        queue_cmd(REQ_READ_PAR,  '0, 6'd33, 33'h1_8000_0000);
        queue_cmd(REQ_WRITE_PAR, 32'h8000_0000, 6'd40, '0);
        drain();

        queue_random(35);
        drain();

        tx_idle_pct = 88;
        rx_idle_pct = 36;
        queue_random(35);
        drain();

        // No idling, but hold the receiver off long enough to back up the input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_hold_req = 1'b1;
        queue_random(35);
        drain();

        repeat (20) @(posedge aclk);
        if (err_count == 0 && pulse_expq.size() == 0) begin
            $display("swd_bit_sequencer_core_tb: done, clean");
        end else begin
            $display("swd_bit_sequencer_core_tb: done, errors");
        end
        $finish;
    end

endmodule
